>>> sv/dec_pkg.sv
// dec_pkg: types, constants and helpers shared by the disc collision block
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package dec_pkg;
	localparam int ID_WIDTH = 16;
	localparam int POS_W = 24;
	localparam int VEL_W = 16;
	localparam int RAD_W = 16;
	localparam int DIST_W = 25;
	localparam int NORM_W = 17;
	// result queue holds every word that can be in flight
	localparam int FIFO_DEPTH = 128;
	localparam int FIFO_AW = 7;

	typedef enum logic [1:0] {
		OUT_RESOLVED = 2'd0,
		OUT_SAME_ID = 2'd1,
		OUT_COINCIDENT = 2'd2,
		OUT_SATURATED = 2'd3
	} outcome_t;

	// one classified pair passed from the front to the back
	typedef struct packed {
		logic signed [DIST_W-1:0] dx;
		logic signed [DIST_W-1:0] dy;
		logic signed [VEL_W-1:0] v1x;
		logic signed [VEL_W-1:0] v1y;
		logic signed [VEL_W-1:0] v2x;
		logic signed [VEL_W-1:0] v2y;
		logic [RAD_W-1:0] r1;
		logic [RAD_W-1:0] r2;
		logic bypass;
		outcome_t code;
	} pair_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] v1x;
		logic signed [VEL_W-1:0] v1y;
		logic signed [VEL_W-1:0] v2x;
		logic signed [VEL_W-1:0] v2y;
		outcome_t code;
	} result_t;
endpackage
`default_nettype wire

>>> sv/dec_front.sv
// dec_front: accepts pairs, forms centre differences and classifies special cases
// depends on dec_pkg
`timescale 1ns / 1ps
`default_nettype none
module dec_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [dec_pkg::ID_WIDTH-1:0] id_a,
	input wire logic [dec_pkg::ID_WIDTH-1:0] id_b,
	input wire logic signed [dec_pkg::POS_W-1:0] x1,
	input wire logic signed [dec_pkg::POS_W-1:0] y1,
	input wire logic signed [dec_pkg::POS_W-1:0] x2,
	input wire logic signed [dec_pkg::POS_W-1:0] y2,
	input wire logic signed [dec_pkg::VEL_W-1:0] v1x,
	input wire logic signed [dec_pkg::VEL_W-1:0] v1y,
	input wire logic signed [dec_pkg::VEL_W-1:0] v2x,
	input wire logic signed [dec_pkg::VEL_W-1:0] v2y,
	input wire logic [dec_pkg::RAD_W-1:0] r1,
	input wire logic [dec_pkg::RAD_W-1:0] r2,
	output dec_pkg::pair_t pair_s1,
	output logic valid_s1
);
	logic signed [dec_pkg::DIST_W-1:0] dx, dy;
	dec_pkg::pair_t p;

	assign dx = {x2[dec_pkg::POS_W-1], x2} - {x1[dec_pkg::POS_W-1], x1};
	assign dy = {y2[dec_pkg::POS_W-1], y2} - {y1[dec_pkg::POS_W-1], y1};

	always_comb begin
		p.dx = dx;
		p.dy = dy;
		p.v1x = v1x;
		p.v1y = v1y;
		p.v2x = v2x;
		p.v2y = v2y;
		p.r1 = r1;
		p.r2 = r2;
		if (id_a == id_b) begin
			p.bypass = 1'b1;
			p.code = dec_pkg::OUT_SAME_ID;
		end else if (dx == '0 && dy == '0) begin
			p.bypass = 1'b1;
			p.code = dec_pkg::OUT_COINCIDENT;
		end else begin
			p.bypass = 1'b0;
			p.code = dec_pkg::OUT_RESOLVED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			pair_s1 <= p;
		end
	end
endmodule
`default_nettype wire

>>> sv/dec_fifo.sv
// dec_fifo: result word queue after the back pipeline, registered read
// depends on dec_pkg
`timescale 1ns / 1ps
`default_nettype none
module dec_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire dec_pkg::result_t wr_data,
	input wire logic rd_en,
	output dec_pkg::result_t rd_data,
	output logic empty
);
	dec_pkg::result_t mem_q [dec_pkg::FIFO_DEPTH];
	dec_pkg::result_t rd_q;
	logic [dec_pkg::FIFO_AW-1:0] wp_q, rp_q;
	logic [dec_pkg::FIFO_AW:0] cnt_q;
	logic rd_v_q;
	logic load;

	// memory count excludes the word held in the read register
	assign load = (cnt_q != '0) && (!rd_v_q || rd_en);
	assign empty = !rd_v_q;
	assign rd_data = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			rd_v_q <= 1'b0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (load) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{dec_pkg::FIFO_AW{1'b0}}, wr_en}
				- {{dec_pkg::FIFO_AW{1'b0}}, load};
			if (load) rd_v_q <= 1'b1;
			else if (rd_en) rd_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
		if (load) rd_q <= mem_q[rp_q];
	end
endmodule
`default_nettype wire

>>> sv/dec_back.sv
// dec_back: pipelined normalize, square root, divides and velocity exchange
// depends on dec_pkg
`timescale 1ns / 1ps
`default_nettype none
module dec_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire dec_pkg::pair_t pair_in,
	output logic out_valid,
	output dec_pkg::result_t res_out
);
	// stage layout: 1 normalize, 2 squares, 3..27 sqrt (one bit each),
	// 28 divide setup, 29..45 normal divides (one bit each), 46..48 projections
	// and numerators, 49 setup, 50..85 mass divides (one bit each),
	// 86 recombination products, 87 rounding and saturation
	localparam int SQ_STEPS = 25;
	localparam int ND_BITS = dec_pkg::NORM_W;
	localparam int AD_BITS = 36;

	typedef struct packed {
		dec_pkg::pair_t p;
		logic signed [dec_pkg::DIST_W-1:0] sx;
		logic signed [dec_pkg::DIST_W-1:0] sy;
		logic [49:0] rem;
		logic [25:0] root;
		logic [49:0] sum;
	} sq_t;

	// valid bits of every stage
	logic st1_v;
	logic [SQ_STEPS:0] sq_v;
	logic [ND_BITS:0] nd_v;
	logic v_p1, v_p2, v_p3;
	logic [AD_BITS:0] ad_v;
	logic v_r1;

	// normalize: shift so max(|dx|,|dy|) reaches bit 23
	function automatic logic [4:0] lead_shift(input logic [24:0] m);
		logic [4:0] k;
		k = 5'd0;
		for (int i = 0; i <= 23; i++) begin
			if (m[i]) k = 5'(23 - i);
		end
		return k;
	endfunction

	logic [24:0] ax, ay, mx;
	assign ax = pair_in.dx[24] ? 25'(-pair_in.dx) : 25'(pair_in.dx);
	assign ay = pair_in.dy[24] ? 25'(-pair_in.dy) : 25'(pair_in.dy);
	assign mx = ax > ay ? ax : ay;

	dec_pkg::pair_t st1_p;
	logic signed [dec_pkg::DIST_W-1:0] st1_sx, st1_sy;
	sq_t sq [SQ_STEPS+1];
	always_ff @(posedge clk) begin
		st1_p <= pair_in;
		if (mx >= 25'(1 << 23) || pair_in.bypass) begin
			st1_sx <= pair_in.dx;
			st1_sy <= pair_in.dy;
		end else begin
			st1_sx <= pair_in.dx <<< lead_shift(mx);
			st1_sy <= pair_in.dy <<< lead_shift(mx);
		end
	end

	// squares
	always_ff @(posedge clk) begin
		sq[0].p <= st1_p;
		sq[0].sx <= st1_sx;
		sq[0].sy <= st1_sy;
		sq[0].sum <= 50'(st1_sx * st1_sx) + 50'(st1_sy * st1_sy);
		sq[0].rem <= '0;
		sq[0].root <= '0;
	end

	// restoring square root, one result bit per stage
	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
		logic [51:0] trial;
		logic [51:0] nrem;
		assign nrem = {sq[g].rem, sq[g].sum[49-2*g -: 2]};
		assign trial = nrem - {sq[g].root, 2'b01};
		always_ff @(posedge clk) begin
			sq[g+1].p <= sq[g].p;
			sq[g+1].sx <= sq[g].sx;
			sq[g+1].sy <= sq[g].sy;
			sq[g+1].sum <= sq[g].sum;
			if (!trial[51]) begin
				sq[g+1].rem <= 50'(trial);
				sq[g+1].root <= {sq[g].root[24:0], 1'b1};
			end else begin
				sq[g+1].rem <= 50'(nrem);
				sq[g+1].root <= {sq[g].root[24:0], 1'b0};
			end
		end
	end

	// normal divide: |d|*2^15 + span/2 over span, restoring, one bit per stage
	typedef struct packed {
		dec_pkg::pair_t p;
		logic [24:0] span;
		logic [41:0] nxr;
		logic [41:0] nyr;
		logic [ND_BITS-1:0] qx;
		logic [ND_BITS-1:0] qy;
		logic sgx;
		logic sgy;
	} nd_t;
	nd_t nd [ND_BITS+1];
	logic [24:0] dist_w;
	logic [24:0] asx, asy;
	assign dist_w = sq[SQ_STEPS].root[24:0];
	assign asx = sq[SQ_STEPS].sx[24] ? 25'(-sq[SQ_STEPS].sx) : 25'(sq[SQ_STEPS].sx);
	assign asy = sq[SQ_STEPS].sy[24] ? 25'(-sq[SQ_STEPS].sy) : 25'(sq[SQ_STEPS].sy);
	always_ff @(posedge clk) begin
		nd[0].p <= sq[SQ_STEPS].p;
		nd[0].span <= (dist_w == '0) ? 25'd1 : dist_w;
		nd[0].nxr <= {2'b0, asx, 15'd0} + 42'(dist_w >> 1);
		nd[0].nyr <= {2'b0, asy, 15'd0} + 42'(dist_w >> 1);
		nd[0].qx <= '0;
		nd[0].qy <= '0;
		nd[0].sgx <= sq[SQ_STEPS].sx[24];
		nd[0].sgy <= sq[SQ_STEPS].sy[24];
	end
	// quotient < 2^17 since |d| <= span
	for (genvar g = 0; g < ND_BITS; g++) begin : g_ndiv
		localparam int B = ND_BITS - 1 - g;
		logic [41:0] tq;
		logic gex, gey;
		assign tq = {17'd0, nd[g].span} << B;
		assign gex = (nd[g].nxr >= tq);
		assign gey = (nd[g].nyr >= tq);
		always_ff @(posedge clk) begin
			nd[g+1].p <= nd[g].p;
			nd[g+1].span <= nd[g].span;
			nd[g+1].nxr <= gex ? nd[g].nxr - tq : nd[g].nxr;
			nd[g+1].nyr <= gey ? nd[g].nyr - tq : nd[g].nyr;
			nd[g+1].qx <= nd[g].qx | ({{(ND_BITS-1){1'b0}}, gex} << B);
			nd[g+1].qy <= nd[g].qy | ({{(ND_BITS-1){1'b0}}, gey} << B);
			nd[g+1].sgx <= nd[g].sgx;
			nd[g+1].sgy <= nd[g].sgy;
		end
	end

	// projections
	logic signed [17:0] nx_w, ny_w;
	assign nx_w = nd[ND_BITS].sgx ? -$signed({1'b0, nd[ND_BITS].qx})
		: $signed({1'b0, nd[ND_BITS].qx});
	assign ny_w = nd[ND_BITS].sgy ? -$signed({1'b0, nd[ND_BITS].qy})
		: $signed({1'b0, nd[ND_BITS].qy});

	dec_pkg::pair_t p_p1;
	logic signed [17:0] nx_p1, ny_p1;
	logic signed [33:0] m1xn, m1yn, m2xn, m2yn, m1xt, m1yt, m2xt, m2yt;
	always_ff @(posedge clk) begin
		p_p1 <= nd[ND_BITS].p;
		nx_p1 <= nx_w;
		ny_p1 <= ny_w;
		m1xn <= nd[ND_BITS].p.v1x * nx_w;
		m1yn <= nd[ND_BITS].p.v1y * ny_w;
		m2xn <= nd[ND_BITS].p.v2x * nx_w;
		m2yn <= nd[ND_BITS].p.v2y * ny_w;
		m1xt <= nd[ND_BITS].p.v1x * (-ny_w);
		m1yt <= nd[ND_BITS].p.v1y * nx_w;
		m2xt <= nd[ND_BITS].p.v2x * (-ny_w);
		m2yt <= nd[ND_BITS].p.v2y * nx_w;
	end

	dec_pkg::pair_t p_p2;
	logic signed [17:0] nx_p2, ny_p2;
	logic signed [34:0] pr1, pr2, qt1, qt2;
	logic signed [17:0] mm1, mm2;
	always_ff @(posedge clk) begin
		p_p2 <= p_p1;
		nx_p2 <= nx_p1;
		ny_p2 <= ny_p1;
		pr1 <= 35'(m1xn) + 35'(m1yn);
		pr2 <= 35'(m2xn) + 35'(m2yn);
		qt1 <= 35'(m1xt) + 35'(m1yt);
		qt2 <= 35'(m2xt) + 35'(m2yt);
		if (p_p1.r1 == '0 && p_p1.r2 == '0) begin
			mm1 <= 18'sd1;
			mm2 <= 18'sd1;
		end else begin
			mm1 <= $signed({2'b0, p_p1.r1});
			mm2 <= $signed({2'b0, p_p1.r2});
		end
	end

	// momentum exchange numerators: products of 35 by 19 bits
	dec_pkg::pair_t p_p3;
	logic signed [17:0] nx_p3, ny_p3;
	logic signed [34:0] qt1_p3, qt2_p3;
	logic signed [55:0] num1, num2;
	logic [17:0] msum_p3;
	logic signed [18:0] dm, m2d, m1d;
	assign dm = 19'(mm1) - 19'(mm2);
	assign m2d = 19'(mm2) <<< 1;
	assign m1d = 19'(mm1) <<< 1;
	always_ff @(posedge clk) begin
		p_p3 <= p_p2;
		nx_p3 <= nx_p2;
		ny_p3 <= ny_p2;
		qt1_p3 <= qt1;
		qt2_p3 <= qt2;
		num1 <= 56'(pr1 * dm) + 56'(pr2 * m2d);
		num2 <= 56'(pr2 * (-dm)) + 56'(pr1 * m1d);
		msum_p3 <= 18'(mm1 + mm2);
	end

	// rounded divide of the numerators by the mass sum, one bit per stage
	typedef struct packed {
		dec_pkg::pair_t p;
		logic signed [17:0] nx;
		logic signed [17:0] ny;
		logic signed [34:0] q1;
		logic signed [34:0] q2;
		logic [17:0] ms;
		logic [56:0] r1;
		logic [56:0] r2;
		logic [AD_BITS-1:0] a1;
		logic [AD_BITS-1:0] a2;
		logic s1;
		logic s2;
	} ad_t;
	ad_t ad [AD_BITS+1];
	always_ff @(posedge clk) begin
		ad[0].p <= p_p3;
		ad[0].nx <= nx_p3;
		ad[0].ny <= ny_p3;
		ad[0].q1 <= qt1_p3;
		ad[0].q2 <= qt2_p3;
		ad[0].ms <= msum_p3;
		ad[0].r1 <= 57'(num1[55] ? -num1 : num1) + 57'(msum_p3 >> 1);
		ad[0].r2 <= 57'(num2[55] ? -num2 : num2) + 57'(msum_p3 >> 1);
		ad[0].a1 <= '0;
		ad[0].a2 <= '0;
		ad[0].s1 <= num1[55];
		ad[0].s2 <= num2[55];
	end
	for (genvar g = 0; g < AD_BITS; g++) begin : g_adiv
		localparam int B = AD_BITS - 1 - g;
		logic [92:0] t;
		logic ge1, ge2;
		assign t = {75'd0, ad[g].ms} << B;
		assign ge1 = ({36'd0, ad[g].r1} >= t);
		assign ge2 = ({36'd0, ad[g].r2} >= t);
		always_ff @(posedge clk) begin
			ad[g+1].p <= ad[g].p;
			ad[g+1].nx <= ad[g].nx;
			ad[g+1].ny <= ad[g].ny;
			ad[g+1].q1 <= ad[g].q1;
			ad[g+1].q2 <= ad[g].q2;
			ad[g+1].ms <= ad[g].ms;
			ad[g+1].r1 <= ge1 ? ad[g].r1 - 57'(t) : ad[g].r1;
			ad[g+1].r2 <= ge2 ? ad[g].r2 - 57'(t) : ad[g].r2;
			ad[g+1].a1 <= ad[g].a1 | ({{(AD_BITS-1){1'b0}}, ge1} << B);
			ad[g+1].a2 <= ad[g].a2 | ({{(AD_BITS-1){1'b0}}, ge2} << B);
			ad[g+1].s1 <= ad[g].s1;
			ad[g+1].s2 <= ad[g].s2;
		end
	end

	// recombination products
	logic signed [36:0] a1_w, a2_w;
	assign a1_w = ad[AD_BITS].s1 ? -$signed({1'b0, ad[AD_BITS].a1})
		: $signed({1'b0, ad[AD_BITS].a1});
	assign a2_w = ad[AD_BITS].s2 ? -$signed({1'b0, ad[AD_BITS].a2})
		: $signed({1'b0, ad[AD_BITS].a2});
	dec_pkg::pair_t p_r1;
	logic signed [55:0] e [8];
	always_ff @(posedge clk) begin
		p_r1 <= ad[AD_BITS].p;
		e[0] <= 56'((-ad[AD_BITS].ny) * ad[AD_BITS].q1);
		e[1] <= 56'(ad[AD_BITS].nx * a1_w);
		e[2] <= 56'(ad[AD_BITS].nx * ad[AD_BITS].q1);
		e[3] <= 56'(ad[AD_BITS].ny * a1_w);
		e[4] <= 56'((-ad[AD_BITS].ny) * ad[AD_BITS].q2);
		e[5] <= 56'(ad[AD_BITS].nx * a2_w);
		e[6] <= 56'(ad[AD_BITS].nx * ad[AD_BITS].q2);
		e[7] <= 56'(ad[AD_BITS].ny * a2_w);
	end

	// round to Q.8 and saturate
	function automatic logic signed [15:0] rnd_sat(input logic signed [56:0] s,
			output logic hit);
		logic [56:0] mag;
		logic [56:0] q;
		logic signed [57:0] r;
		mag = s[56] ? 57'(-s) : 57'(s);
		q = (mag + 57'(1 << 29)) >> 30;
		r = s[56] ? -$signed({1'b0, q}) : $signed({1'b0, q});
		hit = 1'b0;
		if (r > 58'sd32767) begin
			hit = 1'b1;
			return 16'sh7fff;
		end
		if (r < -58'sd32768) begin
			hit = 1'b1;
			return 16'sh8000;
		end
		return r[15:0];
	endfunction

	logic [3:0] hits;
	logic signed [15:0] o [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			o[i] = rnd_sat(57'(e[2*i]) + 57'(e[2*i+1]), hits[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (p_r1.bypass) begin
			res_out.v1x <= p_r1.v1x;
			res_out.v1y <= p_r1.v1y;
			res_out.v2x <= p_r1.v2x;
			res_out.v2y <= p_r1.v2y;
			res_out.code <= p_r1.code;
		end else begin
			res_out.v1x <= o[0];
			res_out.v1y <= o[1];
			res_out.v2x <= o[2];
			res_out.v2y <= o[3];
			res_out.code <= (hits != '0) ? dec_pkg::OUT_SATURATED : dec_pkg::OUT_RESOLVED;
		end
	end

	// valid chain through all stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st1_v <= 1'b0;
			sq_v <= '0;
			nd_v <= '0;
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
			ad_v <= '0;
			v_r1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			st1_v <= in_valid;
			sq_v <= {sq_v[SQ_STEPS-1:0], st1_v};
			nd_v <= {nd_v[ND_BITS-1:0], sq_v[SQ_STEPS]};
			v_p1 <= nd_v[ND_BITS];
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			ad_v <= {ad_v[AD_BITS-1:0], v_p3};
			v_r1 <= ad_v[AD_BITS];
			out_valid <= v_r1;
		end
	end
endmodule
`default_nettype wire

>>> sv/disc_elastic_collision.sv
// disc_elastic_collision: top level, front classifier, back pipeline, result queue
// depends on dec_pkg, dec_front, dec_back, dec_fifo
`timescale 1ns / 1ps
`default_nettype none
// One disc pair is taken per cycle while full is low, and yields one word of
// two new velocities and an outcome code. The front stage registers the pair
// and flags same id or coincident centres; the back is a fully pipelined chain
// (normalize, one-bit-per-stage square root, normal and mass divides,
// multiplies, rounding). An accepted pair passes the front register, the back
// stages and the queue write, and its word shows on the result ports once the
// queue loads it into its read register. Words land in a 128-word result queue
// that reserves room for everything in flight, so full rises only once 128
// words are in flight or waiting, and a stalled consumer never loses a word.
// Sustained rate is one pair per cycle while pop keeps up.
module disc_elastic_collision (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [15:0] id_first,
	input wire logic signed [23:0] first_x,
	input wire logic signed [23:0] first_y,
	input wire logic signed [15:0] first_vx,
	input wire logic signed [15:0] first_vy,
	input wire logic [15:0] first_radius,
	input wire logic [15:0] id_second,
	input wire logic signed [23:0] second_x,
	input wire logic signed [23:0] second_y,
	input wire logic signed [15:0] second_vx,
	input wire logic signed [15:0] second_vy,
	input wire logic [15:0] second_radius,
	output logic empty,
	input wire logic pop,
	output logic signed [15:0] new_first_vx,
	output logic signed [15:0] new_first_vy,
	output logic signed [15:0] new_second_vx,
	output logic signed [15:0] new_second_vy,
	output logic [1:0] outcome
);
	// credit count of words in flight plus queued; bounded by the queue depth
	logic [dec_pkg::FIFO_AW:0] cred_q;
	logic acc, pop_ok, f_valid, b_valid, q_empty;
	dec_pkg::pair_t f_pair;
	dec_pkg::result_t b_res, q_res;

	assign acc = push && !full;
	assign pop_ok = pop && !q_empty;
	assign full = (cred_q >= (dec_pkg::FIFO_AW+1)'(dec_pkg::FIFO_DEPTH));
	assign empty = q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cred_q <= '0;
		else cred_q <= cred_q + {{dec_pkg::FIFO_AW{1'b0}}, acc}
			- {{dec_pkg::FIFO_AW{1'b0}}, pop_ok};
	end

	dec_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(acc),
		.id_a(id_first[dec_pkg::ID_WIDTH-1:0]), .id_b(id_second[dec_pkg::ID_WIDTH-1:0]),
		.x1(first_x), .y1(first_y), .x2(second_x), .y2(second_y),
		.v1x(first_vx), .v1y(first_vy), .v2x(second_vx), .v2y(second_vy),
		.r1(first_radius), .r2(second_radius),
		.pair_s1(f_pair), .valid_s1(f_valid)
	);

	dec_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .pair_in(f_pair),
		.out_valid(b_valid), .res_out(b_res)
	);

	dec_fifo u_rq (
		.clk(clk), .arst_n(arst_n), .wr_en(b_valid), .wr_data(b_res),
		.rd_en(pop_ok), .rd_data(q_res), .empty(q_empty)
	);

	assign new_first_vx = q_res.v1x;
	assign new_first_vy = q_res.v1y;
	assign new_second_vx = q_res.v2x;
	assign new_second_vy = q_res.v2y;
	assign outcome = q_res.code;
endmodule
`default_nettype wire

>>> sv/dec_checker.sv
// dec_checker: port-level assertions for disc_elastic_collision, bound to the top
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module dec_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input wire logic [15:0] new_first_vx,
	input wire logic [1:0] outcome
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(new_first_vx) && $stable(outcome))
		else $error("waiting word changed");
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("word shown during reset");
	a_reset_full: assert property (@(posedge clk) !arst_n |-> !full)
		else $error("full during reset");
endmodule
bind disc_elastic_collision dec_checker u_chk (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .empty(empty),
	.pop(pop), .new_first_vx(new_first_vx), .outcome(outcome)
);
`default_nettype wire
